// File: hdl/trle_pkg.sv
// shared types and constants of the tga run-length pixel encoder
package trle_pkg;

    localparam logic [7:0] RUN_HEADER_BIAS = 8'd127;
    localparam int         WORD_BYTES      = 16;
    localparam int         CHUNK_BYTES     = 4;
    localparam int         ACC_BYTES       = WORD_BYTES + CHUNK_BYTES;

    typedef enum logic [1:0] {
        MODE_EMPTY,
        MODE_SINGLE,
        MODE_EQUAL,
        MODE_RAW
    } run_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_PIX0,
        ST_PIXN,
        ST_DRAIN
    } seq_state_t;

    typedef struct packed {
        logic       final_pixel;
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_in_t;

    typedef struct packed {
        logic [63:0] bytes_low;
        logic [63:0] bytes_high;
        logic [4:0]  byte_count;
        logic        word_last;
        logic        image_done;
    } word_out_t;

    typedef struct packed {
        logic [2:0]                  n;
        logic [CHUNK_BYTES-1:0][7:0] data;
    } chunk_t;

    typedef struct packed {
        logic chunk_valid;
        logic drain;
        logic image_end;
    } pk_ctrl_t;

    typedef struct packed {
        logic chunk_ready;
        logic final_push;
    } pk_stat_t;

endpackage

// File: hdl/trle_ram.sv
// generic single-port-write, registered-read ram
module trle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/trle_packer.sv
// byte packer: gathers header and pixel bytes into 16-byte output words
module trle_packer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  trle_pkg::pk_ctrl_t   ctrl,
    input  trle_pkg::chunk_t     chunk,
    output trle_pkg::pk_stat_t   stat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output trle_pkg::word_out_t  m_data
);
    import trle_pkg::*;

    logic [ACC_BYTES-1:0][7:0]  acc_reg, acc_next;
    logic [4:0]                 acc_cnt_reg, acc_cnt_next;
    logic                       out_valid_reg;
    word_out_t                  out_word_reg;

    logic                       room;
    logic                       want_push;
    logic                       push_last;
    logic                       push_fire;
    logic [4:0]                 push_cnt;
    logic [WORD_BYTES-1:0][7:0] word_bytes;
    word_out_t                  word;

    always_comb begin
        logic [4:0] off;
        off = '0;
        room         = (acc_cnt_reg < 5'(WORD_BYTES));
        want_push    = !room || ctrl.drain;
        push_last    = ctrl.drain && (acc_cnt_reg <= 5'(WORD_BYTES));
        push_cnt     = room ? acc_cnt_reg : 5'(WORD_BYTES);
        push_fire    = want_push && (!out_valid_reg || m_ready);
        stat.chunk_ready = ctrl.chunk_valid && !ctrl.drain && room;
        stat.final_push  = push_fire && push_last;

        for (int k = 0; k < WORD_BYTES; k++) begin
            word_bytes[k] = (5'(k) < push_cnt) ? acc_reg[k] : 8'd0;
        end
        word.bytes_low  = word_bytes[7:0];
        word.bytes_high = word_bytes[15:8];
        word.byte_count = push_cnt;
        word.word_last  = push_last;
        word.image_done = push_last && ctrl.image_end;

        acc_next     = acc_reg;
        acc_cnt_next = acc_cnt_reg;
        if (push_fire) begin
            acc_next = '0;
            for (int j = 0; j < ACC_BYTES - WORD_BYTES; j++) begin
                acc_next[j] = acc_reg[j + WORD_BYTES];
            end
            acc_cnt_next = push_last ? 5'd0 : acc_cnt_reg - 5'(WORD_BYTES);
        end else if (stat.chunk_ready) begin
            // drop the chunk bytes in right after the bytes already held
            for (int j = 0; j < ACC_BYTES; j++) begin
                off = 5'(j) - acc_cnt_reg;
                if ((5'(j) >= acc_cnt_reg) && (off < {2'b00, chunk.n})) begin
                    acc_next[j] = chunk.data[off[1:0]];
                end
            end
            acc_cnt_next = acc_cnt_reg + {2'b00, chunk.n};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            acc_cnt_reg <= acc_cnt_next;
            if (push_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (push_fire) begin
            out_word_reg <= word;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

endmodule

// File: hdl/tga_rle_pixel_encoder_top.sv
// top level of the tga run-length pixel encoder
// Takes one BGRA pixel per request and emits TGA run-length packets (header byte, then
// B,G,R and A when alpha_enable is set) packed 16 bytes to a result word. A pixel that
// completes no packet is taken without leaving the idle state, so the input stays ready. A
// pixel that flushes a packet holds the input until the packet's header and pixels are
// written and the last word is handed to the output register; it writes two packets when
// the final pixel also ends a broken run. The packer takes one header or pixel per cycle
// while it has room and is not handing out a word. Pixels of a raw run past the first
// sit in a MAX_RUN-deep ram and are read back as the packer takes them, through its
// registered read port while the packet is written. The output word stays registered, so
// the next pixel is taken while the last word of a packet still waits for m_ready.
module tga_rle_pixel_encoder_top #(
    parameter int MAX_RUN = 128
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  trle_pkg::pixel_in_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output trle_pkg::word_out_t  m_data,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data
);
    import trle_pkg::*;

    localparam int CNT_W = $clog2(MAX_RUN + 1);
    localparam int AW    = $clog2(MAX_RUN);
    localparam logic [CNT_W-1:0] RUN_LIMIT = CNT_W'(MAX_RUN);

    // run state: raw pixels past the first live in the ram, the first one in first_reg
    logic             alpha_en_reg;
    run_mode_t        mode_reg, mode_next;
    logic [31:0]      prev_reg, prev_next;
    logic [31:0]      first_reg, first_next;
    logic [CNT_W-1:0] eq_reg, eq_next;
    logic [CNT_W-1:0] raw_reg, raw_next;

    // packet writer: current packet and an optional second one queued behind it
    seq_state_t       state_reg, state_next;
    logic             cur_raw_reg;
    logic [CNT_W-1:0] cur_cnt_reg;
    logic [31:0]      cur_pix_reg;
    logic             nxt_valid_reg;
    logic             nxt_raw_reg;
    logic [CNT_W-1:0] nxt_cnt_reg;
    logic [31:0]      nxt_pix_reg;
    logic [AW-1:0]    idx_reg, idx_next;
    logic             fin_reg;

    logic             accept;
    logic [31:0]      pix;
    logic             fin;

    // packet broken by this pixel
    logic             fa_valid;
    logic             fa_raw;
    logic [CNT_W-1:0] fa_cnt;
    logic [31:0]      fa_pix;
    // packet flushed by the final pixel
    logic             fx_raw;
    logic [CNT_W-1:0] fx_cnt;
    logic [31:0]      fx_pix;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [31:0]      rd_data;

    logic             finish;
    logic             load_nxt;
    logic [7:0]       header;
    logic [31:0]      pix_sel;
    chunk_t           chunk;
    pk_ctrl_t         pk_ctrl;
    pk_stat_t         pk_stat;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign pix     = {s_data.alpha, s_data.red, s_data.green, s_data.blue};
    assign fin     = s_data.final_pixel;

    // run tracking for the incoming pixel
    always_comb begin
        logic start;
        start      = 1'b0;
        mode_next  = mode_reg;
        prev_next  = prev_reg;
        first_next = first_reg;
        eq_next    = eq_reg;
        raw_next   = raw_reg;
        wr_en      = 1'b0;
        wr_addr    = raw_reg[AW-1:0];
        fa_valid   = 1'b0;
        fa_raw     = 1'b0;
        fa_cnt     = eq_reg;
        fa_pix     = prev_reg;

        case (mode_reg)
            MODE_EMPTY: begin
                start = 1'b1;
            end
            MODE_SINGLE: begin
                if (pix == prev_reg) begin
                    mode_next = MODE_EQUAL;
                    eq_next   = CNT_W'(2);
                end else begin
                    wr_en     = 1'b1;
                    wr_addr   = AW'(1);
                    raw_next  = CNT_W'(2);
                    prev_next = pix;
                    mode_next = MODE_RAW;
                end
            end
            MODE_EQUAL: begin
                if ((pix == prev_reg) && (eq_reg < RUN_LIMIT)) begin
                    eq_next = eq_reg + 1'b1;
                end else begin
                    fa_valid = 1'b1;
                    start    = 1'b1;
                end
            end
            MODE_RAW: begin
                if ((pix != prev_reg) && (raw_reg < RUN_LIMIT)) begin
                    wr_en     = 1'b1;
                    raw_next  = raw_reg + 1'b1;
                    prev_next = pix;
                end else begin
                    // repeat or full run: raw run goes out as it stands
                    fa_valid = 1'b1;
                    fa_raw   = 1'b1;
                    fa_cnt   = raw_reg;
                    fa_pix   = first_reg;
                    start    = 1'b1;
                end
            end
            default: begin
                start = 1'b1;
            end
        endcase

        if (start) begin
            mode_next  = MODE_SINGLE;
            prev_next  = pix;
            first_next = pix;
            raw_next   = CNT_W'(1);
            eq_next    = '0;
        end

        fx_raw = (mode_next != MODE_EQUAL);
        fx_cnt = fx_raw ? raw_next : eq_next;
        fx_pix = fx_raw ? first_next : prev_next;

        if (fin) begin
            mode_next = MODE_EMPTY;
            prev_next = '0;
            eq_next   = '0;
            raw_next  = '0;
        end

        wr_en = wr_en && accept;
    end

    // packet writer: header, first pixel, then the rest of a raw run from the ram
    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        rd_en       = 1'b0;
        rd_addr     = AW'(1);
        finish      = 1'b0;
        header      = cur_raw_reg ? (8'(cur_cnt_reg) - 8'd1)
                                  : (8'(cur_cnt_reg) + RUN_HEADER_BIAS);
        pix_sel     = (state_reg == ST_PIXN) ? rd_data : cur_pix_reg;
        chunk.data  = pix_sel;
        chunk.n     = alpha_en_reg ? 3'd4 : 3'd3;
        pk_ctrl.chunk_valid = 1'b0;
        pk_ctrl.drain       = 1'b0;
        pk_ctrl.image_end   = fin_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept && (fa_valid || fin)) begin
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD: begin
                chunk.data          = {24'd0, header};
                chunk.n             = 3'd1;
                pk_ctrl.chunk_valid = 1'b1;
                if (pk_stat.chunk_ready) begin
                    state_next = ST_PIX0;
                end
            end
            ST_PIX0: begin
                pk_ctrl.chunk_valid = 1'b1;
                if (pk_stat.chunk_ready) begin
                    if (cur_raw_reg && (cur_cnt_reg != CNT_W'(1))) begin
                        rd_en      = 1'b1;
                        rd_addr    = AW'(1);
                        idx_next   = AW'(1);
                        state_next = ST_PIXN;
                    end else begin
                        finish = 1'b1;
                    end
                end
            end
            ST_PIXN: begin
                pk_ctrl.chunk_valid = 1'b1;
                if (pk_stat.chunk_ready) begin
                    if ((CNT_W'(idx_reg) + 1'b1) == cur_cnt_reg) begin
                        finish = 1'b1;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + 1'b1;
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                pk_ctrl.drain = 1'b1;
                if (pk_stat.final_push) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish) begin
            state_next = nxt_valid_reg ? ST_HEAD : ST_DRAIN;
        end
        load_nxt = finish && nxt_valid_reg;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_en_reg  <= 1'b1;
            mode_reg      <= MODE_EMPTY;
            prev_reg      <= '0;
            eq_reg        <= '0;
            raw_reg       <= '0;
            state_reg     <= ST_IDLE;
            nxt_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                alpha_en_reg <= cfg_wr_data;
            end
            if (accept) begin
                mode_reg      <= mode_next;
                prev_reg      <= prev_next;
                eq_reg        <= eq_next;
                raw_reg       <= raw_next;
                nxt_valid_reg <= fa_valid && fin;
            end else if (load_nxt) begin
                nxt_valid_reg <= 1'b0;
            end
            state_reg <= state_next;
        end
    end

    // packet descriptors and first raw pixel
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (accept) begin
            first_reg <= first_next;
            fin_reg   <= fin;
            if (fa_valid) begin
                cur_raw_reg <= fa_raw;
                cur_cnt_reg <= fa_cnt;
                cur_pix_reg <= fa_pix;
            end else begin
                cur_raw_reg <= fx_raw;
                cur_cnt_reg <= fx_cnt;
                cur_pix_reg <= fx_pix;
            end
            nxt_raw_reg <= fx_raw;
            nxt_cnt_reg <= fx_cnt;
            nxt_pix_reg <= fx_pix;
        end else if (load_nxt) begin
            cur_raw_reg <= nxt_raw_reg;
            cur_cnt_reg <= nxt_cnt_reg;
            cur_pix_reg <= nxt_pix_reg;
        end
    end

    // raw run pixel store
    trle_ram #(
        .WIDTH (32),
        .DEPTH (MAX_RUN)
    ) u_raw_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (pix),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // byte packing and output word register
    trle_packer u_packer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (pk_ctrl),
        .chunk   (chunk),
        .stat    (pk_stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: hdl/trle_checker.sv
// port-level checks of the output word stream, bound to the top level
module trle_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input trle_pkg::word_out_t m_data
);

    // image end only on the closing word of a pixel
    a_done_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.image_done |-> m_data.word_last)
        else $error("image_done without word_last");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.byte_count != 5'd0) && (m_data.byte_count <= 5'd16))
        else $error("byte_count out of range");

    // only the closing word of a pixel may be partly filled
    a_full_inner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.word_last |-> (m_data.byte_count == 5'd16))
        else $error("inner word not full");

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("output request dropped before it was taken");

endmodule

bind tga_rle_pixel_encoder_top trle_checker u_trle_checker (.*);
